// File: design/tkmh_pkg.sv
`timescale 1ns / 1ps

package tkmh_pkg;

	localparam int SPEED_W   = 17;
	localparam int EFF_W     = 27;
	localparam int LIMIT_W   = 11;
	localparam int SCORE_W   = 54;
	localparam int MOD_W     = 30;
	localparam int RED_SHIFT = 29;
	localparam int Q_W       = SCORE_W - RED_SHIFT;
	localparam int REM_W     = MOD_W + 2;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
	localparam logic [MOD_W-1:0]   SCORE_MOD = 30'd1000000007;
	localparam logic [Q_W-1:0]     MOD_RECIP = Q_W'((64'd1 << SCORE_W) / 64'(SCORE_MOD));
	localparam logic [REM_W-1:0]   MOD_X1    = REM_W'(SCORE_MOD);
	localparam logic [REM_W-1:0]   MOD_X2    = MOD_X1 << 1;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [EFF_W-1:0]   efficiency;
		logic               last_item;
	} in_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] best_score;
		logic [MOD_W-1:0]   best_score_mod;
		logic               final_result;
	} out_item_t;

	typedef struct packed {
		logic               push;
		logic               pop;
		logic [SPEED_W-1:0] value;
	} cell_op_t;

endpackage

// File: design/top_k_min_heap_score_tracker.sv
`timescale 1ns / 1ps

// top-k score tracker over a sorted row of speed cells
// in channel: in_valid / in_ready with in_item (speed, efficiency, last_item);
//   items are expected in non-increasing efficiency order
// out channel: out_valid / out_ready with out_item (best_score, best_score_mod,
//   final_result), one result transaction per input transaction
// cfg channel: cfg_valid / cfg_ready with cfg_data = team_limit, always ready;
//   write only while no item is in flight
// items are taken one at a time: a new item is accepted only once the last one has
//   passed the insert, multiply, compare and extract steps and the three-stage
//   modulo reduction that follows them, and its result has been loaded
// the cell row inserts a speed in the PUSH state and removes the minimum in the POP state
// reset: team_limit returns to 1, count, sum and best clear, no result pending;
//   cell contents are not cleared
// a stalled receiver holds the result register; the next item is still taken
//   and worked on, and waits for the register before its result is loaded
// last_item clears count, sum and best once its result is loaded
module top_k_min_heap_score_tracker #(
	parameter int MAX_TEAM = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  tkmh_pkg::in_item_t                    in_item,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output tkmh_pkg::out_item_t                   out_item,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tkmh_pkg::LIMIT_W-1:0]          cfg_data
);

	localparam int CNT_W  = $clog2(MAX_TEAM + 1);
	localparam int SUM_W  = tkmh_pkg::SPEED_W + CNT_W;
	localparam int PROD_W = SUM_W + tkmh_pkg::EFF_W;
	localparam int CMP_W  = (PROD_W > tkmh_pkg::SCORE_W) ? PROD_W : tkmh_pkg::SCORE_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PUSH = 6'b000010,
		S_MUL  = 6'b000100,
		S_BEST = 6'b001000,
		S_POP  = 6'b010000,
		S_MOD  = 6'b100000
	} state_t;

	state_t                              state_q;
	logic [CNT_W-1:0]                    count_q;
	logic [SUM_W-1:0]                    sum_q;
	logic [tkmh_pkg::SCORE_W-1:0]        best_q;
	logic [tkmh_pkg::LIMIT_W-1:0]        team_limit_q;
	logic                                out_valid_q;
	tkmh_pkg::out_item_t                 out_item_q;

	logic [tkmh_pkg::SPEED_W-1:0]        speed_q;
	logic [tkmh_pkg::EFF_W-1:0]          eff_q;
	logic                                last_q;
	logic [PROD_W-1:0]                   prod_s1;

	logic [31:0]                         limit32;
	logic [31:0]                         k32;
	logic [CNT_W-1:0]                    eff_k;
	logic [CMP_W-1:0]                    prod_ext;
	logic [tkmh_pkg::SCORE_W-1:0]        score_sat;
	logic                                do_pop;
	logic                                out_free;
	logic                                load_out;
	logic                                mod_busy;
	logic [tkmh_pkg::MOD_W-1:0]          mod_res;
	tkmh_pkg::cell_op_t                  cell_op;

	logic [tkmh_pkg::SPEED_W-1:0]        cell_val [MAX_TEAM];
	logic                                cell_gt  [MAX_TEAM];

	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (state_q == S_MOD) && !mod_busy && out_free;

	always_comb begin
		limit32 = 32'(team_limit_q);
		if (limit32 == 32'd0) begin
			k32 = 32'd1;
		end else if (limit32 > 32'(MAX_TEAM)) begin
			k32 = 32'(MAX_TEAM);
		end else begin
			k32 = limit32;
		end
		eff_k = CNT_W'(k32);
	end

	assign do_pop = (state_q == S_POP) && (count_q >= eff_k);

	assign prod_ext  = CMP_W'(prod_s1);
	assign score_sat = (prod_ext > CMP_W'(tkmh_pkg::SCORE_MAX)) ? tkmh_pkg::SCORE_MAX
	                                                           : prod_ext[tkmh_pkg::SCORE_W-1:0];

	assign cell_op.push  = state_q == S_PUSH;
	assign cell_op.pop   = do_pop;
	assign cell_op.value = speed_q;

	for (genvar i = 0; i < MAX_TEAM; i++) begin : g_cell
		logic [tkmh_pkg::SPEED_W-1:0] lv;
		logic                         lg;
		logic [tkmh_pkg::SPEED_W-1:0] rv;

		if (i == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = cell_val[i-1];
			assign lg = cell_gt[i-1];
		end

		if (i == MAX_TEAM - 1) begin : g_last
			assign rv = '0;
		end else begin : g_next
			assign rv = cell_val[i+1];
		end

		tkmh_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.count     (count_q),
			.left_val  (lv),
			.left_gt   (lg),
			.right_val (rv),
			.val       (cell_val[i]),
			.gt        (cell_gt[i])
		);
	end

	tkmh_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_POP),
		.operand (best_q),
		.busy    (mod_busy),
		.result  (mod_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			sum_q        <= '0;
			best_q       <= '0;
			team_limit_q <= tkmh_pkg::LIMIT_W'(1);
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				team_limit_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					count_q <= count_q + CNT_W'(1);
					sum_q   <= sum_q + SUM_W'(speed_q);
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_BEST;
				end
				S_BEST: begin
					if (score_sat > best_q) begin
						best_q <= score_sat;
					end
					state_q <= S_POP;
				end
				S_POP: begin
					if (do_pop) begin
						count_q <= count_q - CNT_W'(1);
						sum_q   <= sum_q - SUM_W'(cell_val[0]);
					end
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (load_out) begin
						if (last_q) begin
							count_q <= '0;
							sum_q   <= '0;
							best_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			speed_q <= in_item.speed;
			eff_q   <= in_item.efficiency;
			last_q  <= in_item.last_item;
		end
		if (state_q == S_MUL) begin
			prod_s1 <= {{tkmh_pkg::EFF_W{1'b0}}, sum_q} * {{SUM_W{1'b0}}, eff_q};
		end
		if (load_out) begin
			out_item_q.best_score     <= best_q;
			out_item_q.best_score_mod <= mod_res;
			out_item_q.final_result   <= last_q;
		end
	end

endmodule

// File: design/tkmh_cell.sv
`timescale 1ns / 1ps

module tkmh_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 11
) (
	input  logic                           clk,
	input  tkmh_pkg::cell_op_t             op,
	input  logic [CNT_W-1:0]               count,
	input  logic [tkmh_pkg::SPEED_W-1:0]   left_val,
	input  logic                           left_gt,
	input  logic [tkmh_pkg::SPEED_W-1:0]   right_val,
	output logic [tkmh_pkg::SPEED_W-1:0]   val,
	output logic                           gt
);

	logic [tkmh_pkg::SPEED_W-1:0] val_q;
	logic                         occupied;

	// empty cells act as larger than any speed
	assign occupied = count > CNT_W'(IDX);
	assign gt       = !occupied || (val_q > op.value);
	assign val      = val_q;

	always_ff @(posedge clk) begin
		if (op.push) begin
			if (gt) begin
				val_q <= left_gt ? left_val : op.value;
			end
		end else if (op.pop) begin
			val_q <= right_val;
		end
	end

endmodule

// File: design/tkmh_mod_unit.sv
`timescale 1ns / 1ps

module tkmh_mod_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tkmh_pkg::SCORE_W-1:0]   operand,
	output logic                           busy,
	output logic [tkmh_pkg::MOD_W-1:0]     result
);

	logic                                        run_s1;
	logic                                        run_s2;
	logic [tkmh_pkg::REM_W-1:0]                  x_s1;
	logic [tkmh_pkg::Q_W-1:0]                    q_s1;
	logic [tkmh_pkg::REM_W-1:0]                  qp_s2;
	logic [tkmh_pkg::REM_W-1:0]                  rem_s3;
	logic [2*tkmh_pkg::Q_W-1:0]                  recip_prod;
	logic [tkmh_pkg::Q_W+tkmh_pkg::MOD_W-1:0]    qp_full;
	logic [tkmh_pkg::REM_W-1:0]                  rem_red;

	assign busy = run_s1 || run_s2;

	// quotient estimate from the top bits, at most two short
	assign recip_prod = {{tkmh_pkg::Q_W{1'b0}}, operand[tkmh_pkg::SCORE_W-1:tkmh_pkg::RED_SHIFT]}
	                    * {{tkmh_pkg::Q_W{1'b0}}, tkmh_pkg::MOD_RECIP};
	assign qp_full    = {{tkmh_pkg::MOD_W{1'b0}}, q_s1}
	                    * {{tkmh_pkg::Q_W{1'b0}}, tkmh_pkg::SCORE_MOD};

	always_comb begin
		priority if (rem_s3 >= tkmh_pkg::MOD_X2) begin
			rem_red = rem_s3 - tkmh_pkg::MOD_X2;
		end else if (rem_s3 >= tkmh_pkg::MOD_X1) begin
			rem_red = rem_s3 - tkmh_pkg::MOD_X1;
		end else begin
			rem_red = rem_s3;
		end
	end

	assign result = rem_red[tkmh_pkg::MOD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_s1 <= 1'b0;
			run_s2 <= 1'b0;
		end else begin
			run_s1 <= start;
			run_s2 <= run_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_s1 <= operand[tkmh_pkg::REM_W-1:0];
			q_s1 <= recip_prod[2*tkmh_pkg::Q_W-1:tkmh_pkg::Q_W];
		end
		if (run_s1) begin
			qp_s2 <= qp_full[tkmh_pkg::REM_W-1:0];
		end
		if (run_s2) begin
			rem_s3 <= x_s1 - qp_s2;
		end
	end

endmodule
